// ===== src/kmh_pkg.sv =====
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared constants, types and helper functions of the k-mer histogram counter.
// ----------------------------------------------------------------------------
package kmh_pkg;

   // store and alphabet dimensions
   localparam int INDEX_BITS  = 16;
   localparam int MAX_SYMBOLS = 8;
   localparam int MAX_K       = 16;

   localparam int STORE_SIZE = 1 << INDEX_BITS;
   localparam int NSYM_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int SIDX_W     = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int K_W        = $clog2(MAX_K + 1);
   localparam int SPAN_W     = INDEX_BITS + 1;
   localparam int PROD_W     = SPAN_W + NSYM_W;
   localparam int REM_W      = INDEX_BITS + 1;
   localparam int CNT_W      = $clog2(((MAX_K > PROD_W) ? MAX_K : PROD_W) + 1);

   // fixed field widths
   localparam int CHAR_W    = 8;
   localparam int NSYM_FW   = 4;
   localparam int KLEN_FW   = 5;
   localparam int COUNT_W   = 32;
   localparam int KIDX_W    = 16;
   localparam int CSR_DW    = 64;
   localparam int CSR_AW    = 5;
   localparam int REGIDX_W  = CSR_AW - 3;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [REGIDX_W-1:0]   reg_index_type;

   localparam reg_index_type REG_SYMBOL_CHARS = reg_index_type'(0);
   localparam reg_index_type REG_NUM_SYMBOLS  = reg_index_type'(1);
   localparam reg_index_type REG_KMER_LENGTH  = reg_index_type'(2);

   localparam logic [CSR_DW-1:0]  RST_SYMBOL_CHARS = 64'd1414988609;
   localparam logic [NSYM_FW-1:0] RST_NUM_SYMBOLS  = 4'd4;
   localparam logic [KLEN_FW-1:0] RST_KMER_LENGTH  = 5'd8;

   localparam logic [SPAN_W-1:0]  SPAN_SAT   = SPAN_W'(STORE_SIZE + 1);
   localparam logic [SPAN_W-1:0]  SPAN_LIMIT = SPAN_W'(STORE_SIZE);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   typedef struct packed {
      logic [CSR_DW-1:0]  symbol_chars;
      logic [NSYM_FW-1:0] num_symbols;
      logic [KLEN_FW-1:0] kmer_length;
   } cfg_type;

   typedef enum logic {
      ALU_MAC,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] b;
      logic [NSYM_W-1:0] m;
   } alu_req_type;

   typedef struct packed {
      logic [PROD_W-1:0] result;
      logic              ge;
   } alu_rsp_type;

   typedef struct packed {
      logic               we;
      index_type          addr;
      logic [COUNT_W-1:0] wdata;
   } store_req_type;

   typedef struct packed {
      logic              hit;
      logic [SIDX_W-1:0] idx;
   } sym_match_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPAN,
      ST_MAC,
      ST_DIV,
      ST_WIN,
      ST_RD,
      ST_UPD,
      ST_DONE
   } state_type;

   function automatic logic [NSYM_W-1:0] eff_symbols(input logic [NSYM_FW-1:0] n);
      if (32'(n) > MAX_SYMBOLS) begin
         return NSYM_W'(MAX_SYMBOLS);
      end
      return NSYM_W'(n);
   endfunction

   function automatic logic [K_W-1:0] eff_length(input logic [KLEN_FW-1:0] k);
      if (32'(k) > MAX_K) begin
         return K_W'(MAX_K);
      end
      return K_W'(k);
   endfunction

   function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // highest matching symbol wins
   function automatic sym_match_type lookup_symbol(input logic [CHAR_W-1:0] c,
                                                   input logic [CSR_DW-1:0] chars,
                                                   input logic [NSYM_W-1:0] n);
      sym_match_type     m;
      logic [CHAR_W-1:0] s;
      m = '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         s = chars[CHAR_W*i +: CHAR_W];
         if (NSYM_W'(i) < n && (c == s || c == lower_ascii(s))) begin
            m.hit = 1'b1;
            m.idx = SIDX_W'(i);
         end
      end
      return m;
   endfunction

endpackage

// ===== src/kmh_alu.sv =====
// ----------------------------------------------------------------------------
// kmh_alu
// Shared arithmetic unit: small multiply-accumulate or compare-subtract.
// ----------------------------------------------------------------------------
module kmh_alu
   import kmh_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] diff;

   assign prod = PROD_W'(req.a * req.m) + req.b;
   assign diff = req.a - req.b;

   always_comb begin
      rsp.ge = (req.a >= req.b);
      unique case (req.op)
         ALU_MAC: begin
            rsp.result = prod;
         end
         ALU_SUB: begin
            rsp.result = diff;
         end
      endcase
   end

endmodule

// ===== src/kmh_store.sv =====
// ----------------------------------------------------------------------------
// kmh_store
// Histogram count memory, one read/write port, registered read data.
// ----------------------------------------------------------------------------
module kmh_store
   import kmh_pkg::*;
(
   input  logic               clock,
   input  store_req_type      req,
   output logic [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [STORE_SIZE];
   logic [COUNT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rd_data = rdata_ff;

endmodule

// ===== src/kmh_csr.sv =====
// ----------------------------------------------------------------------------
// kmh_csr
// APB-style configuration registers: alphabet, alphabet size, window length.
// ----------------------------------------------------------------------------
module kmh_csr
   import kmh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [CSR_DW-1:0]  chars_ff, chars_in;
   logic [NSYM_FW-1:0] nsym_ff, nsym_in;
   logic [KLEN_FW-1:0] klen_ff, klen_in;
   reg_index_type      reg_idx;
   logic               wr_en;

   assign reg_idx = paddr[CSR_AW-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      chars_in = chars_ff;
      nsym_in  = nsym_ff;
      klen_in  = klen_ff;
      prdata   = '0;
      unique case (reg_idx)
         REG_SYMBOL_CHARS: begin
            prdata = chars_ff;
            if (wr_en) begin
               chars_in = pwdata;
            end
         end
         REG_NUM_SYMBOLS: begin
            prdata = CSR_DW'(nsym_ff);
            if (wr_en) begin
               nsym_in = pwdata[NSYM_FW-1:0];
            end
         end
         REG_KMER_LENGTH: begin
            prdata = CSR_DW'(klen_ff);
            if (wr_en) begin
               klen_in = pwdata[KLEN_FW-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= RST_SYMBOL_CHARS;
         nsym_ff  <= RST_NUM_SYMBOLS;
         klen_ff  <= RST_KMER_LENGTH;
      end else begin
         chars_ff <= chars_in;
         nsym_ff  <= nsym_in;
         klen_ff  <= klen_in;
      end
   end

   assign cfg.symbol_chars = chars_ff;
   assign cfg.num_symbols  = nsym_ff;
   assign cfg.kmer_length  = klen_ff;

endmodule

// ===== src/kmer_histogram_counter_top.sv =====
// ----------------------------------------------------------------------------
// kmer_histogram_counter_top
// Rolling k-mer counter with a saturating 32-bit histogram store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 65536-entry count store to zero, one entry
// per cycle, and holds req_stall high until done; configuration writes are
// taken meanwhile. Items are then handled one at a time by a sequencer around
// a single shared multiply-accumulate / compare-subtract unit. Every
// transaction first raises N to the power k by repeated multiply, stopping
// early on overflow. A read then passes through the store read, update and
// done states. A counted character takes one multiply-accumulate for the
// rolling index, a 21-step restoring reduction modulo N^k, and a
// read-modify-write of the store. The next transaction may be accepted while
// the previous result waits on rsp.
// ----------------------------------------------------------------------------
module kmer_histogram_counter_top
   import kmh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [7:0]        req_symbol_byte,
   input  logic              req_seq_start,
   input  logic [15:0]       req_read_index,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kmer_valid,
   output logic [15:0]       rsp_kmer_index,
   output logic [31:0]       rsp_count,
   output logic              rsp_config_error,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type            cfg;
   logic [NSYM_W-1:0]  n_eff;
   logic [K_W-1:0]     k_eff;
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   store_req_type      st_req;
   logic [COUNT_W-1:0] st_rdata;
   sym_match_type      match;

   state_type          state_ff, state_in;
   index_type          clr_ff, clr_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   index_type          win_ff, win_in;
   logic [K_W-1:0]     run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [PROD_W-1:0]  div_ff, div_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   index_type          addr_ff, addr_in;
   logic               kind_ff, kind_in;
   logic               seq_ff, seq_in;
   logic               hit_ff, hit_in;
   logic [SIDX_W-1:0]  sidx_ff, sidx_in;
   logic [KIDX_W-1:0]  rdidx_ff, rdidx_in;
   logic               res_valid_ff, res_valid_in;
   logic [KIDX_W-1:0]  res_index_ff, res_index_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_err_ff, res_err_in;
   logic               o_kvalid_ff, o_kvalid_in;
   logic [KIDX_W-1:0]  o_index_ff, o_index_in;
   logic [COUNT_W-1:0] o_count_ff, o_count_in;
   logic               o_err_ff, o_err_in;

   logic               err_now;
   logic               read_ok;
   logic [REM_W-1:0]   shifted;
   logic [K_W-1:0]     run_next;
   logic [COUNT_W-1:0] count_inc;

   kmh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kmh_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   kmh_store u_store (
      .clock   (clock),
      .req     (st_req),
      .rd_data (st_rdata)
   );

   assign n_eff     = eff_symbols(cfg.num_symbols);
   assign k_eff     = eff_length(cfg.kmer_length);
   assign match     = lookup_symbol(req_symbol_byte, cfg.symbol_chars, n_eff);
   assign err_now   = span_ff > SPAN_LIMIT;
   assign read_ok   = {16'd0, rdidx_ff} < 32'(STORE_SIZE);
   assign shifted   = {rem_ff[REM_W-2:0], div_ff[PROD_W-1]};
   assign run_next  = (run_ff < k_eff) ? run_ff + K_W'(1) : run_ff;
   assign count_inc = (st_rdata == COUNT_MAX) ? st_rdata : st_rdata + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      win_in       = win_ff;
      run_in       = run_ff;
      span_in      = span_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      addr_in      = addr_ff;
      kind_in      = kind_ff;
      seq_in       = seq_ff;
      hit_in       = hit_ff;
      sidx_in      = sidx_ff;
      rdidx_in     = rdidx_ff;
      res_valid_in = res_valid_ff;
      res_index_in = res_index_ff;
      res_count_in = res_count_ff;
      res_err_in   = res_err_ff;
      o_kvalid_in  = o_kvalid_ff;
      o_index_in   = o_index_ff;
      o_count_in   = o_count_ff;
      o_err_in     = o_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      alu_req      = '{op: ALU_MAC, a: '0, b: '0, m: '0};
      st_req       = '{we: 1'b0, addr: addr_ff, wdata: '0};

      unique case (state_ff)
         ST_CLEAR: begin
            st_req.we   = 1'b1;
            st_req.addr = clr_ff;
            clr_in      = clr_ff + index_type'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               kind_in  = req_kind;
               seq_in   = req_seq_start;
               hit_in   = match.hit;
               sidx_in  = match.idx;
               rdidx_in = req_read_index;
               span_in  = SPAN_W'(1);
               step_in  = '0;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (step_ff == CNT_W'(k_eff) || err_now) begin
               res_err_in   = err_now;
               res_valid_in = 1'b0;
               res_index_in = '0;
               res_count_in = '0;
               if (kind_ff) begin
                  res_index_in = rdidx_ff;
                  addr_in      = index_type'(rdidx_ff);
                  state_in     = read_ok ? ST_RD : ST_DONE;
               end else if (err_now || k_eff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  if (seq_ff || !hit_ff) begin
                     win_in = '0;
                     run_in = '0;
                  end
                  state_in = hit_ff ? ST_MAC : ST_DONE;
               end
            end else begin
               alu_req = '{op: ALU_MAC, a: PROD_W'(span_ff), b: '0, m: n_eff};
               span_in = (alu_rsp.result > PROD_W'(STORE_SIZE)) ?
                         SPAN_SAT : SPAN_W'(alu_rsp.result);
               step_in = step_ff + CNT_W'(1);
            end
         end
         ST_MAC: begin
            alu_req  = '{op: ALU_MAC, a: PROD_W'(win_ff), b: PROD_W'(sidx_ff), m: n_eff};
            div_in   = alu_rsp.result;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring reduction modulo N^k, one dividend bit a cycle
            alu_req = '{op: ALU_SUB, a: PROD_W'(shifted), b: PROD_W'(span_ff), m: '0};
            rem_in  = alu_rsp.ge ? REM_W'(alu_rsp.result) : shifted;
            div_in  = div_ff << 1;
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(PROD_W - 1)) begin
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            win_in = index_type'(rem_ff);
            run_in = run_next;
            if (run_next >= k_eff) begin
               addr_in  = index_type'(rem_ff);
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            res_valid_in = 1'b1;
            if (kind_ff) begin
               res_count_in = st_rdata;
               res_index_in = rdidx_ff;
            end else begin
               st_req.we    = 1'b1;
               st_req.wdata = count_inc;
               res_count_in = count_inc;
               res_index_in = KIDX_W'(addr_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_kvalid_in  = res_valid_ff;
               o_index_in   = res_index_ff;
               o_count_in   = res_count_ff;
               o_err_in     = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         win_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         win_ff       <= win_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff      <= span_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      addr_ff      <= addr_in;
      kind_ff      <= kind_in;
      seq_ff       <= seq_in;
      hit_ff       <= hit_in;
      sidx_ff      <= sidx_in;
      rdidx_ff     <= rdidx_in;
      res_valid_ff <= res_valid_in;
      res_index_ff <= res_index_in;
      res_count_ff <= res_count_in;
      res_err_ff   <= res_err_in;
      o_kvalid_ff  <= o_kvalid_in;
      o_index_ff   <= o_index_in;
      o_count_ff   <= o_count_in;
      o_err_ff     <= o_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kmer_valid   = o_kvalid_ff;
   assign rsp_kmer_index   = o_index_ff;
   assign rsp_count        = o_count_ff;
   assign rsp_config_error = o_err_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> state_ff == ST_IDLE)
      else $error("transaction accepted outside idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result issued without a finished transaction");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      st_req.we |-> (state_ff == ST_CLEAR || state_ff == ST_UPD))
      else $error("store written outside clear or update");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIN |-> REM_W'(rem_ff) < REM_W'(span_ff))
      else $error("rolling index not reduced below span");

endmodule
